// File: rtl/fcn3_pkg.sv
package fcn3_pkg;

	localparam int COORD_BITS = 16;
	localparam int SLOPE_BITS = 16;
	localparam int DIST_BITS = 31;
	localparam int SLOPE_FRAC = 12;
	localparam logic [SLOPE_BITS-1:0] SLOPE_RESET = 16'd7095;
	localparam logic signed [COORD_BITS-1:0] POS_MISSING = 16'sd32767;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0] dist_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t vel_x;
		coord_t vel_y;
	} person_t;

	typedef struct packed {
		logic valid;
		dist_t dist_sq;
		person_t p;
	} cell_t;

	typedef struct packed {
		logic last;
		logic qual;
		dist_t dist_sq;
		person_t p;
	} front_t;

	typedef struct packed {
		logic found;
		person_t p;
	} result_t;

endpackage

// File: rtl/front_cone_nearest_three_select_unit.sv
// a closing transaction passes stage 1 and stage 2, then its list's results load the output row
// throughput: one input transaction per cycle through a two-stage front end and a row of cells,
// except while a closing transaction waits in stage 2 until the output row is free to take the
// snapshot; a list delivers its KEEP_COUNT results one per output transfer
// reset: asynchronous, clears valid bits and counters, not cell data; cone_slope returns to 7095
module front_cone_nearest_three_select_unit #(
	parameter int KEEP_COUNT = 3,
	parameter int INDEX_BITS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fcn3_pkg::SLOPE_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic signed [15:0] vel_x,
	input logic signed [15:0] vel_y,
	input logic end_of_list,
	output logic out_valid,
	input logic out_ready,
	output logic [((KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1)-1:0] rank,
	output logic found,
	output logic signed [15:0] sel_pos_x,
	output logic signed [15:0] sel_pos_y,
	output logic signed [15:0] sel_vel_x,
	output logic signed [15:0] sel_vel_y,
	output logic [INDEX_BITS-1:0] sel_index,
	output logic final_result
);
	import fcn3_pkg::*;

	localparam int RANK_BITS = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam int CNT_BITS = $clog2(KEEP_COUNT + 1);
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
	localparam logic [INDEX_BITS-1:0] INDEX_ONE = INDEX_BITS'(1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(KEEP_COUNT);
	localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

	logic [SLOPE_BITS-1:0] cone_slope_q;
	logic [INDEX_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] ocnt_q;
	result_t obuf_q [KEEP_COUNT];
	logic [INDEX_BITS-1:0] oidx_q [KEEP_COUNT];

	logic adv;
	logic take;
	logic snap_ok;
	logic snap;
	logic out_fire;
	logic v_s2;
	front_t f_s2;
	logic [INDEX_BITS-1:0] idx_s2;
	person_t in_p;
	cell_t new_c;
	logic upd;

	cell_t cur_c [KEEP_COUNT];
	cell_t nxt_c [KEEP_COUNT];
	logic [INDEX_BITS-1:0] cur_idx [KEEP_COUNT];
	logic [INDEX_BITS-1:0] nxt_idx [KEEP_COUNT];
	logic hit [KEEP_COUNT];

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_slope_q <= SLOPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cone_slope_q <= cfg_data;
		end
	end

	// input side and list position
	assign out_fire = out_valid && out_ready;
	assign snap_ok = (ocnt_q == '0) || ((ocnt_q == CNT_ONE) && out_ready);
	assign adv = !(v_s2 && f_s2.last && !snap_ok);
	assign in_ready = adv;
	assign take = in_valid && in_ready;
	assign in_p = '{pos_x: pos_x, pos_y: pos_y, vel_x: vel_x, vel_y: vel_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			if (end_of_list) begin
				cnt_q <= '0;
			end else if (cnt_q != INDEX_MAX) begin
				cnt_q <= cnt_q + INDEX_ONE;
			end
		end
	end

	fcn3_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.take(take),
		.slope(cone_slope_q),
		.in_p(in_p),
		.in_last(end_of_list),
		.in_idx(cnt_q),
		.v_s2(v_s2),
		.f_s2(f_s2),
		.idx_s2(idx_s2)
	);

	// row of ranking cells
	assign upd = v_s2 && adv && f_s2.qual;
	assign snap = v_s2 && adv && f_s2.last;
	assign new_c = '{valid: 1'b1, dist_sq: f_s2.dist_sq, p: f_s2.p};

	for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_cell
		if (k == 0) begin : g_head
			fcn3_cell #(
				.INDEX_BITS(INDEX_BITS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.upd(upd),
				.clear(snap),
				.new_c(new_c),
				.new_idx(idx_s2),
				.ins_in(1'b0),
				.nbr_c(new_c),
				.nbr_idx(idx_s2),
				.cur_c(cur_c[k]),
				.cur_idx(cur_idx[k]),
				.nxt_c(nxt_c[k]),
				.nxt_idx(nxt_idx[k]),
				.hit(hit[k])
			);
		end else begin : g_body
			fcn3_cell #(
				.INDEX_BITS(INDEX_BITS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.upd(upd),
				.clear(snap),
				.new_c(new_c),
				.new_idx(idx_s2),
				.ins_in(hit[k-1]),
				.nbr_c(cur_c[k-1]),
				.nbr_idx(cur_idx[k-1]),
				.cur_c(cur_c[k]),
				.cur_idx(cur_idx[k]),
				.nxt_c(nxt_c[k]),
				.nxt_idx(nxt_idx[k]),
				.hit(hit[k])
			);
		end
	end

	// output row, loaded from the cells at the end of a list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else if (snap) begin
			ocnt_q <= CNT_FULL;
		end else if (out_fire) begin
			ocnt_q <= ocnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (snap) begin
			for (int k = 0; k < KEEP_COUNT; k++) begin
				obuf_q[k].found <= nxt_c[k].valid;
				if (nxt_c[k].valid) begin
					obuf_q[k].p <= nxt_c[k].p;
					oidx_q[k] <= nxt_idx[k];
				end else begin
					obuf_q[k].p <= '{pos_x: POS_MISSING, pos_y: POS_MISSING,
						vel_x: '0, vel_y: '0};
					oidx_q[k] <= '0;
				end
			end
		end else if (out_fire) begin
			for (int k = 0; k < KEEP_COUNT - 1; k++) begin
				obuf_q[k] <= obuf_q[k+1];
				oidx_q[k] <= oidx_q[k+1];
			end
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign rank = RANK_BITS'(CNT_FULL - ocnt_q);
	assign found = obuf_q[0].found;
	assign sel_pos_x = obuf_q[0].p.pos_x;
	assign sel_pos_y = obuf_q[0].p.pos_y;
	assign sel_vel_x = obuf_q[0].p.vel_x;
	assign sel_vel_y = obuf_q[0].p.vel_y;
	assign sel_index = oidx_q[0];
	assign final_result = (ocnt_q == CNT_ONE);

	// checks
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= CNT_FULL)
		else $error("output count beyond row length");

	a_snap_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap |-> (ocnt_q == '0) || ((ocnt_q == CNT_ONE) && out_fire))
		else $error("snapshot over undelivered results");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s2 && f_s2.last && (ocnt_q != '0))
		else $error("input stalled without a pending list end");

	a_snap_load: assert property (@(posedge clk) disable iff (!arst_n)
		snap |=> out_valid && (ocnt_q == CNT_FULL))
		else $error("snapshot did not fill the output row");

	for (genvar k = 1; k < KEEP_COUNT; k++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			cur_c[k].valid |-> cur_c[k-1].valid
				&& (cur_c[k-1].dist_sq <= cur_c[k].dist_sq))
			else $error("cell row out of order");
	end

endmodule

// File: rtl/fcn3_front.sv
module fcn3_front #(
	parameter int INDEX_BITS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic take,
	input logic [fcn3_pkg::SLOPE_BITS-1:0] slope,
	input fcn3_pkg::person_t in_p,
	input logic in_last,
	input logic [INDEX_BITS-1:0] in_idx,
	output logic v_s2,
	output fcn3_pkg::front_t f_s2,
	output logic [INDEX_BITS-1:0] idx_s2
);
	import fcn3_pkg::*;

	logic v_s1;
	logic last_s1;
	logic xpos_s1;
	logic [30:0] rhs_s1;
	logic [27:0] lhs_s1;
	logic [29:0] xsq_s1;
	logic [31:0] ysq_s1;
	person_t p_s1;
	logic [INDEX_BITS-1:0] idx_s1;

	logic [15:0] ay;
	logic [14:0] xm;

	assign ay = in_p.pos_y[15] ? (~in_p.pos_y + 16'd1) : in_p.pos_y;
	assign xm = in_p.pos_x[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_last;
			xpos_s1 <= !in_p.pos_x[15] && (in_p.pos_x != '0);
			rhs_s1 <= 31'(slope) * 31'(xm);
			lhs_s1 <= {ay, {SLOPE_FRAC{1'b0}}};
			xsq_s1 <= 30'(xm) * 30'(xm);
			ysq_s1 <= 32'(ay) * 32'(ay);
			p_s1 <= in_p;
			idx_s1 <= in_idx;
		end
	end

	// stage 2: distance and cone test
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2.last <= last_s1;
			f_s2.qual <= xpos_s1 && ({3'b000, lhs_s1} < rhs_s1);
			f_s2.dist_sq <= DIST_BITS'({1'b0, xsq_s1}) + DIST_BITS'(ysq_s1);
			f_s2.p <= p_s1;
			idx_s2 <= idx_s1;
		end
	end

endmodule

// File: rtl/fcn3_cell.sv
module fcn3_cell #(
	parameter int INDEX_BITS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input logic clear,
	input fcn3_pkg::cell_t new_c,
	input logic [INDEX_BITS-1:0] new_idx,
	input logic ins_in,
	input fcn3_pkg::cell_t nbr_c,
	input logic [INDEX_BITS-1:0] nbr_idx,
	output fcn3_pkg::cell_t cur_c,
	output logic [INDEX_BITS-1:0] cur_idx,
	output fcn3_pkg::cell_t nxt_c,
	output logic [INDEX_BITS-1:0] nxt_idx,
	output logic hit
);
	import fcn3_pkg::*;

	logic valid_q;
	dist_t dist_q;
	person_t p_q;
	logic [INDEX_BITS-1:0] idx_q;

	assign cur_c = '{valid: valid_q, dist_sq: dist_q, p: p_q};
	assign cur_idx = idx_q;

	// strict compare keeps the earlier item ahead on a tie
	assign hit = ins_in || (upd && (!valid_q || (new_c.dist_sq < dist_q)));

	always_comb begin
		if (ins_in) begin
			nxt_c = nbr_c;
			nxt_idx = nbr_idx;
		end else if (hit) begin
			nxt_c = new_c;
			nxt_idx = new_idx;
		end else begin
			nxt_c = cur_c;
			nxt_idx = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		dist_q <= nxt_c.dist_sq;
		p_q <= nxt_c.p;
		idx_q <= nxt_idx;
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import fcn3_pkg::*;

	localparam int KEEP = 3;
	localparam int IDX_BITS = 6;
	localparam int INDEX_LIMIT = (1 << IDX_BITS) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [1:0] rank;
		logic found;
		person_t p;
		logic [IDX_BITS-1:0] index;
		logic final_result;
	} pick_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [SLOPE_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	coord_t pos_x;
	coord_t pos_y;
	coord_t vel_x;
	coord_t vel_y;
	logic end_of_list;
	logic out_valid;
	logic out_ready;
	logic [1:0] rank;
	logic found;
	coord_t sel_pos_x;
	coord_t sel_pos_y;
	coord_t sel_vel_x;
	coord_t sel_vel_y;
	logic [IDX_BITS-1:0] sel_index;
	logic final_result;

	// predictor state
	logic [SLOPE_BITS-1:0] slope_now;
	logic [31:0] top_dist [KEEP];
	person_t top_person [KEEP];
	logic [IDX_BITS-1:0] top_index [KEEP];
	bit top_valid [KEEP];
	int list_pos;
	person_t prev_person;

	pick_t pending_picks [$];
	int failures;
	int mismatches;
	int cycle_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_cycles;

	front_cone_nearest_three_select_unit #(
		.KEEP_COUNT(KEEP),
		.INDEX_BITS(IDX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.end_of_list(end_of_list),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rank(rank),
		.found(found),
		.sel_pos_x(sel_pos_x),
		.sel_pos_y(sel_pos_y),
		.sel_vel_x(sel_vel_x),
		.sel_vel_y(sel_vel_y),
		.sel_index(sel_index),
		.final_result(final_result)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void clear_list();
		for (int k = 0; k < KEEP; k++) begin
			top_dist[k] = 32'h7FFF_FFFF;
			top_person[k] = '0;
			top_index[k] = '0;
			top_valid[k] = 1'b0;
		end
		list_pos = 0;
	endfunction

	// front cone test, insertion into the three nearest, and the results of a closing transaction
	function automatic void rank_person(person_t p, bit last);
		longint ay;
		longint lhs;
		longint rhs;
		logic [31:0] d;
		int slot;
		int idx;
		pick_t r;
		idx = list_pos;
		if (list_pos < INDEX_LIMIT)
			list_pos++;
		if (p.pos_x > 0) begin
			ay = (p.pos_y < 0) ? -longint'(p.pos_y) : longint'(p.pos_y);
			lhs = ay << SLOPE_FRAC;
			rhs = longint'(slope_now) * longint'(p.pos_x);
			if (lhs < rhs) begin
				d = 32'(longint'(p.pos_x) * longint'(p.pos_x)
					+ longint'(p.pos_y) * longint'(p.pos_y));
				slot = KEEP;
				for (int k = 0; k < KEEP; k++)
					if (slot == KEEP && (!top_valid[k] || d < top_dist[k]))
						slot = k;
				if (slot < KEEP) begin
					for (int k = KEEP - 1; k > slot; k--) begin
						top_dist[k] = top_dist[k-1];
						top_person[k] = top_person[k-1];
						top_index[k] = top_index[k-1];
						top_valid[k] = top_valid[k-1];
					end
					top_dist[slot] = d;
					top_person[slot] = p;
					top_index[slot] = IDX_BITS'(idx);
					top_valid[slot] = 1'b1;
				end
			end
		end
		if (last) begin
			for (int k = 0; k < KEEP; k++) begin
				r.rank = 2'(k);
				r.found = top_valid[k];
				if (top_valid[k]) begin
					r.p = top_person[k];
					r.index = top_index[k];
				end else begin
					r.p.pos_x = POS_MISSING;
					r.p.pos_y = POS_MISSING;
					r.p.vel_x = '0;
					r.p.vel_y = '0;
					r.index = '0;
				end
				r.final_result = (k == KEEP - 1);
				pending_picks = {pending_picks, r};
			end
			clear_list();
		end
	endfunction

	// receiver: long hold-off when requested, random idling otherwise
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		pick_t want;
		pick_t got;
		if (arst_n && out_valid && out_ready) begin
			got.rank = rank;
			got.found = found;
			got.p.pos_x = sel_pos_x;
			got.p.pos_y = sel_pos_y;
			got.p.vel_x = sel_vel_x;
			got.p.vel_y = sel_vel_y;
			got.index = sel_index;
			got.final_result = final_result;
			if (pending_picks.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %p", got);
			end else begin
				want = pending_picks.pop_front();
				if (got.rank !== want.rank || got.found !== want.found
					|| got.p.pos_x !== want.p.pos_x || got.p.pos_y !== want.p.pos_y
					|| got.p.vel_x !== want.p.vel_x || got.p.vel_y !== want.p.vel_y
					|| got.index !== want.index
					|| got.final_result !== want.final_result) begin
					failures++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at cycle %0d: expected %p, actual %p",
							cycle_count, want, got);
				end
			end
		end
	end

	task automatic send_person(person_t p, bit last);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= p.pos_x;
		pos_y <= p.pos_y;
		vel_x <= p.vel_x;
		vel_y <= p.vel_y;
		end_of_list <= last;
		do
			@(posedge clk);
		while (!in_ready);
		rank_person(p, last);
		prev_person = p;
		@(negedge clk);
	endtask

	task automatic send_xy(int x, int y, int vx, int vy, bit last);
		person_t p;
		p.pos_x = coord_t'(x);
		p.pos_y = coord_t'(y);
		p.vel_x = coord_t'(vx);
		p.vel_y = coord_t'(vy);
		send_person(p, last);
	endtask

	task automatic stop_offering();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		while (pending_picks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_slope(logic [SLOPE_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		slope_now = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic person_t random_person();
		person_t p;
		int lim;
		int mode;
		mode = $urandom_range(99);
		p.vel_x = coord_t'($urandom);
		p.vel_y = coord_t'($urandom);
		if (mode < 40) begin
			p.pos_x = coord_t'($urandom);
			p.pos_y = coord_t'($urandom);
		end else if (mode < 85) begin
			p.pos_x = coord_t'($urandom_range(1, 3000));
			lim = (int'(p.pos_x) * int'(slope_now)) >>> SLOPE_FRAC;
			if (lim > 32767)
				lim = 32767;
			p.pos_y = coord_t'($urandom_range(0, lim));
			if ($urandom_range(1))
				p.pos_y = -p.pos_y;
		end else begin
			// mirror of the previous person: same distance
			p.pos_x = prev_person.pos_x;
			p.pos_y = -prev_person.pos_y;
		end
		return p;
	endfunction

	task automatic send_random_list(int len);
		for (int i = 0; i < len; i++)
			send_person(random_person(), i == len - 1);
	endtask

	task automatic test_cone_edges();
		send_xy(0, 0, 5, 5, 1'b0);
		send_xy(-32768, 0, 1, 1, 1'b0);
		send_xy(4096, 7095, 2, 2, 1'b0);
		send_xy(4096, 7094, 3, 3, 1'b0);
		send_xy(100, 50, 4, 4, 1'b0);
		send_xy(100, -50, 6, 6, 1'b0);
		send_xy(32767, -32768, 32767, -32768, 1'b0);
		send_xy(1, 0, -32768, 32767, 1'b1);
		send_xy(-5, 3, 0, 0, 1'b0);
		send_xy(20, 32767, 0, 0, 1'b1);
		stop_offering();
		settle();
	endtask

	task automatic test_slope_extremes();
		write_slope(16'd0);
		send_xy(10, 0, 7, 7, 1'b1);
		stop_offering();
		settle();
		write_slope(16'hFFFF);
		send_xy(1, 15, 1, -1, 1'b0);
		send_xy(1, 16, 2, -2, 1'b1);
		stop_offering();
		settle();
		write_slope(16'd4096);
		send_xy(50, 50, 0, 0, 1'b0);
		send_xy(50, -49, -1, 1, 1'b1);
		stop_offering();
		settle();
	endtask

	task automatic test_long_list();
		write_slope(SLOPE_RESET);
		for (int i = 0; i < 70; i++) begin
			if (i == 10 || i == 63 || i == 66 || i == 69)
				send_xy(200 - i, i, i, -i, i == 69);
			else
				send_xy(-1 - i, i, 0, 0, 1'b0);
		end
		stop_offering();
		settle();
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items,
		logic [SLOPE_BITS-1:0] slope);
		int sent;
		int len;
		write_slope(slope);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(19) == 0)
				len = $urandom_range(60, 70);
			else
				len = $urandom_range(1, 8);
			send_random_list(len);
			sent += len;
			// stretches without idling
			if ($urandom_range(3) == 0) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = tx_pct;
				rx_idle_pct = rx_pct;
			end
		end
		stop_offering();
		settle();
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		@(posedge clk);
		hold_cycles = 200;
		@(negedge clk);
		for (int i = 0; i < 12; i++)
			send_random_list(4);
		stop_offering();
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		vel_x = '0;
		vel_y = '0;
		end_of_list = 1'b0;
		out_ready = 1'b0;
		failures = 0;
		mismatches = 0;
		cycle_count = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_cycles = 0;
		prev_person = '0;
		slope_now = SLOPE_RESET;
		clear_list();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_cone_edges();
		test_slope_extremes();
		test_long_list();
		test_random_traffic(28, 69, 120, SLOPE_RESET);
		test_random_traffic(69, 28, 120, 16'($urandom_range(1024, 20000)));
		test_random_traffic(0, 0, 120, 16'($urandom));
		test_output_stall();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_picks.size() != 0)
			failures++;
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/fcn3_pkg.sv
rtl/fcn3_front.sv
rtl/fcn3_cell.sv
rtl/front_cone_nearest_three_select_unit.sv
dv/tb.sv
